// ----- src/positional_list_store_assert.svh -----
// ----------------------------------------------------------------------------
// positional_list_store_assert.svh
// Assertion macros for the positional list store.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define PLS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("positional_list_store: check failed");
// Checked on every edge, reset included.
`define PLS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("positional_list_store: check failed");
`else
`define PLS_ASSERT(lbl, clk, rstn, prop)
`define PLS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- src/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants of the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

// ----- src/positional_list_store.sv -----
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed 32-bit entries addressed by position.
// ----------------------------------------------------------------------------
// One word is taken per clock and its result word appears in the output
// register on the next clock; a new word is taken while a result waits as long
// as the output side is ready. The list is a row of CAPACITY cells: an insert
// or delete shifts every cell above the position by one slot in that single
// cycle, and a read picks the addressed cell off a one-hot select across the
// row. Reset clears the entry count and the output valid flag; cell contents
// need no clearing.
`include "positional_list_store_assert.svh"

module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_mode,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_ok,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [CNT_W-1:0]         o_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]     r_entry_count;
    logic [CW-1:0]     n_entry_count;
    logic              r_out_valid;
    logic              r_res_ok;
    logic [DATA_W-1:0] r_res_rd;
    logic [CW-1:0]     r_res_count;

    logic              w_accept;
    logic              w_ok;
    logic [MW-1:0]     w_pos_ext;
    logic [MW-1:0]     w_cnt_ext;
    logic [DATA_W-1:0] w_rd_sel;
    t_cell_ctrl        w_ctrl;
    t_mode             w_mode;

    logic [DATA_W-1:0] w_cell_val [CAPACITY];
    logic [DATA_W-1:0] w_cell_rd  [CAPACITY];
    logic [DATA_W-1:0] w_rd_chain [CAPACITY+1];

    assign o_ready   = !r_out_valid || i_ready;
    assign w_accept  = i_valid && o_ready;
    assign w_mode    = t_mode'(i_mode);
    assign w_pos_ext = MW'(i_position);
    assign w_cnt_ext = MW'(r_entry_count);

    always_comb begin
        w_ok          = 1'b0;
        n_entry_count = r_entry_count;
        w_ctrl.ins    = 1'b0;
        w_ctrl.del    = 1'b0;
        w_ctrl.pos    = i_position;
        w_ctrl.value  = i_value;
        unique case (w_mode)
            MODE_INSERT: begin
                w_ok = (w_pos_ext <= w_cnt_ext) && (r_entry_count < CW'(CAPACITY));
                if (w_accept && w_ok) begin
                    w_ctrl.ins    = 1'b1;
                    n_entry_count = r_entry_count + CW'(1);
                end
            end
            MODE_DELETE: begin
                w_ok = (w_pos_ext < w_cnt_ext);
                if (w_accept && w_ok) begin
                    w_ctrl.del    = 1'b1;
                    n_entry_count = r_entry_count - CW'(1);
                end
            end
            MODE_READ: begin
                w_ok = (w_pos_ext < w_cnt_ext);
            end
            MODE_CLEAR: begin
                w_ok = 1'b1;
                if (w_accept) begin
                    n_entry_count = '0;
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    assign w_rd_chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_val[g];
        end else begin : g_mid_r
            assign w_right = w_cell_val[g+1];
        end

        pls_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell_val[g]),
            .o_rd    (w_cell_rd[g])
        );

        assign w_rd_chain[g+1] = w_rd_chain[g] | w_cell_rd[g];
    end

    assign w_rd_sel = (w_mode == MODE_READ && w_ok) ? w_rd_chain[CAPACITY] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_entry_count <= n_entry_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_ok    <= w_ok;
            r_res_rd    <= w_rd_sel;
            r_res_count <= n_entry_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ok         = r_res_ok;
    assign o_read_value = r_res_rd;
    assign o_count      = CNT_W'(r_res_count);

    `PLS_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> (r_entry_count == '0 && !r_out_valid))
    `PLS_ASSERT(a_count_bound, i_clk, i_rst_n, r_entry_count <= CW'(CAPACITY))
    `PLS_ASSERT(a_fail_zero, i_clk, i_rst_n, (r_out_valid && !r_res_ok) |-> (r_res_rd == '0))
    `PLS_ASSERT(a_clear, i_clk, i_rst_n, (w_accept && w_mode == MODE_CLEAR) |=> (r_entry_count == '0 && r_res_ok && r_res_count == '0))
    `PLS_ASSERT(a_full_insert, i_clk, i_rst_n, (w_accept && w_mode == MODE_INSERT && r_entry_count == CW'(CAPACITY)) |=> (!r_res_ok && r_entry_count == CW'(CAPACITY)))
    `PLS_ASSERT(a_count_match, i_clk, i_rst_n, $past(w_accept) |-> (r_res_count == r_entry_count))

endmodule

// ----- src/pls_cell.sv -----
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds an entry and shifts it to or from its neighbours.
// ----------------------------------------------------------------------------
module pls_cell
    import pls_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_value,
    output logic [DATA_W-1:0] o_rd
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              w_eq;
    logic              w_above;

    assign w_eq    = (IDX == int'(i_ctrl.pos));
    assign w_above = (IDX > int'(i_ctrl.pos));

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins) begin
            if (w_above) begin
                n_value = i_left;
            end else if (w_eq) begin
                n_value = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            if (w_eq || w_above) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_rd    = w_eq ? r_value : '0;

endmodule
